/* src/assert_macros.svh */
// Assertion helpers for the queue RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

`define SPQ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`define SPQ_ASSERT_IMPL(lbl, pre, post, msg) \
  `SPQ_ASSERT(lbl, (pre) |-> (post), msg)

`define SPQ_ASSERT_NEXT(lbl, pre, post, msg) \
  `SPQ_ASSERT(lbl, (pre) |=> (post), msg)

`else

`define SPQ_ASSERT(lbl, prop, msg)

`define SPQ_ASSERT_IMPL(lbl, pre, post, msg)

`define SPQ_ASSERT_NEXT(lbl, pre, post, msg)

`endif

`endif

/* src/spq_pkg.sv */
package spq_pkg;

  localparam int PRIO_W       = 4;
  localparam int DEPTH_DEF    = 16;
  localparam int TAG_BITS_DEF = 16;

  localparam logic FUNC_ENQ = 1'b0;
  localparam logic FUNC_DEQ = 1'b1;

  typedef enum logic [1:0] {
    STAT_ENQ   = 2'd0,
    STAT_DEQ   = 2'd1,
    STAT_EMPTY = 2'd2,
    STAT_FULL  = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ENQ,
    ST_DEQ,
    ST_DONE
  } state_t;

endpackage

/* src/spq_mem.sv */
module spq_mem
  import spq_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF,
  parameter int WIDTH = PRIO_W + TAG_BITS_DEF,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

/* src/spq_ctrl.sv */
module spq_ctrl
  import spq_pkg::*;
#(
  parameter int DEPTH    = DEPTH_DEF,
  parameter int TAG_BITS = TAG_BITS_DEF,
  localparam int IDX_W = $clog2(DEPTH),
  localparam int CNT_W = $clog2(DEPTH + 1),
  localparam int ENT_W = PRIO_W + TAG_BITS
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                in_func,
  input  logic [PRIO_W-1:0]   in_priority_req,
  input  logic [TAG_BITS-1:0] in_tag,
  output logic                mem_we,
  output logic [IDX_W-1:0]    mem_waddr,
  output logic [ENT_W-1:0]    mem_wdata,
  output logic [IDX_W-1:0]    mem_raddr,
  input  logic [ENT_W-1:0]    mem_rdata,
  output logic                res_valid,
  input  logic                res_ready,
  output status_t             res_status,
  output logic [PRIO_W-1:0]   res_priority,
  output logic [TAG_BITS-1:0] res_tag,
  output logic [CNT_W-1:0]    res_occupancy
);

  state_t              state_r, state_nxt;
  logic [IDX_W-1:0]    head_r, head_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic [IDX_W-1:0]    idx_r, idx_nxt;
  logic [PRIO_W-1:0]   prio_r, prio_nxt;
  logic [TAG_BITS-1:0] tag_r, tag_nxt;
  status_t             status_r, status_nxt;
  logic [PRIO_W-1:0]   res_prio_r, res_prio_nxt;
  logic [TAG_BITS-1:0] res_tag_r, res_tag_nxt;

  logic                full;
  logic                empty;
  logic [CNT_W-1:0]    cnt_m1;
  logic [PRIO_W-1:0]   rd_prio;
  logic                stop;

  function automatic logic [IDX_W-1:0] phys_addr(input logic [IDX_W-1:0] base,
                                                 input logic [IDX_W-1:0] off);
    logic [IDX_W:0] s;
    s = {1'b0, base} + {1'b0, off};
    if (s >= (IDX_W + 1)'(DEPTH)) begin
      s = s - (IDX_W + 1)'(DEPTH);
    end
    return s[IDX_W-1:0];
  endfunction

  assign full    = (cnt_r == CNT_W'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign cnt_m1  = cnt_r - CNT_W'(1);
  assign rd_prio = mem_rdata[TAG_BITS +: PRIO_W];
  assign stop    = (idx_r == '0) || (rd_prio >= prio_r);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          if (in_func == FUNC_DEQ) begin
            state_nxt = empty ? ST_DONE : ST_DEQ;
          end else begin
            state_nxt = full ? ST_DONE : ST_ENQ;
          end
        end
      end
      ST_ENQ: begin
        if (stop) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DEQ: begin
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (res_ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    in_ready     = 1'b0;
    res_valid    = 1'b0;
    mem_we       = 1'b0;
    mem_waddr    = phys_addr(head_r, idx_r);
    mem_wdata    = {prio_r, tag_r};
    mem_raddr    = head_r;
    head_nxt     = head_r;
    cnt_nxt      = cnt_r;
    idx_nxt      = idx_r;
    prio_nxt     = prio_r;
    tag_nxt      = tag_r;
    status_nxt   = status_r;
    res_prio_nxt = res_prio_r;
    res_tag_nxt  = res_tag_r;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if ((in_func == FUNC_ENQ) && !empty) begin
          mem_raddr = phys_addr(head_r, cnt_m1[IDX_W-1:0]);
        end
        if (in_valid) begin
          prio_nxt     = in_priority_req;
          tag_nxt      = in_tag;
          idx_nxt      = cnt_r[IDX_W-1:0];
          res_prio_nxt = '0;
          res_tag_nxt  = '0;
          if (in_func == FUNC_DEQ) begin
            status_nxt = empty ? STAT_EMPTY : STAT_DEQ;
          end else begin
            status_nxt = full ? STAT_FULL : STAT_ENQ;
          end
        end
      end
      ST_ENQ: begin
        mem_we = 1'b1;
        if (stop) begin
          mem_wdata = {prio_r, tag_r};
          cnt_nxt   = cnt_r + CNT_W'(1);
        end else begin
          mem_wdata = mem_rdata;
          idx_nxt   = idx_r - IDX_W'(1);
          if ({1'b0, idx_r} >= (IDX_W + 1)'(2)) begin
            mem_raddr = phys_addr(head_r, idx_r - IDX_W'(2));
          end
        end
      end
      ST_DEQ: begin
        res_prio_nxt = rd_prio;
        res_tag_nxt  = mem_rdata[TAG_BITS-1:0];
        head_nxt     = phys_addr(head_r, IDX_W'(1));
        cnt_nxt      = cnt_m1;
      end
      ST_DONE: begin
        res_valid = 1'b1;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      head_r  <= '0;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      head_r  <= head_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r      <= idx_nxt;
    prio_r     <= prio_nxt;
    tag_r      <= tag_nxt;
    status_r   <= status_nxt;
    res_prio_r <= res_prio_nxt;
    res_tag_r  <= res_tag_nxt;
  end

  assign res_status    = status_r;
  assign res_priority  = res_prio_r;
  assign res_tag       = res_tag_r;
  assign res_occupancy = cnt_r;

endmodule

/* src/stable_priority_queue.sv */
// Flow: a dequeue goes through ST_DEQ, which takes the head entry, and an enqueue through
// ST_ENQ, which shifts s entries (s up to DEPTH - 1) before it writes; an empty dequeue or
// a full enqueue goes straight to ST_DONE. Results wait in ST_DONE for the output register.
// Throughput: one request at a time; the entry memory moves one entry per cycle.
// Reset: synchronous, active low; clears count, head pointer and control only, the
// entry memory is not cleared and there is no clearing pass.
`include "assert_macros.svh"

module stable_priority_queue
  import spq_pkg::*;
#(
  parameter int DEPTH    = DEPTH_DEF,
  parameter int TAG_BITS = TAG_BITS_DEF,
  localparam int IDX_W = $clog2(DEPTH),
  localparam int CNT_W = $clog2(DEPTH + 1),
  localparam int ENT_W = PRIO_W + TAG_BITS
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                in_func,
  input  logic [PRIO_W-1:0]   in_priority_req,
  input  logic [TAG_BITS-1:0] in_tag,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [1:0]          out_status,
  output logic [PRIO_W-1:0]   out_priority,
  output logic [TAG_BITS-1:0] out_tag,
  output logic [CNT_W-1:0]    out_occupancy
);

  logic                mem_we;
  logic [IDX_W-1:0]    mem_waddr;
  logic [ENT_W-1:0]    mem_wdata;
  logic [IDX_W-1:0]    mem_raddr;
  logic [ENT_W-1:0]    mem_rdata;

  logic                res_valid;
  logic                res_ready;
  status_t             res_status;
  logic [PRIO_W-1:0]   res_priority;
  logic [TAG_BITS-1:0] res_tag;
  logic [CNT_W-1:0]    res_occupancy;

  logic                out_valid_r, out_valid_nxt;
  logic [1:0]          out_status_r;
  logic [PRIO_W-1:0]   out_prio_r;
  logic [TAG_BITS-1:0] out_tag_r;
  logic [CNT_W-1:0]    out_occ_r;

  logic                out_is_full;
  logic                out_is_empty;

  spq_ctrl #(
    .DEPTH    (DEPTH),
    .TAG_BITS (TAG_BITS)
  ) u_ctrl (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_func         (in_func),
    .in_priority_req (in_priority_req),
    .in_tag          (in_tag),
    .mem_we          (mem_we),
    .mem_waddr       (mem_waddr),
    .mem_wdata       (mem_wdata),
    .mem_raddr       (mem_raddr),
    .mem_rdata       (mem_rdata),
    .res_valid       (res_valid),
    .res_ready       (res_ready),
    .res_status      (res_status),
    .res_priority    (res_priority),
    .res_tag         (res_tag),
    .res_occupancy   (res_occupancy)
  );

  spq_mem #(
    .DEPTH (DEPTH),
    .WIDTH (ENT_W)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  assign res_ready = !out_valid_r || out_ready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    priority if (res_valid && res_ready) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_status_r <= res_status;
      out_prio_r   <= res_priority;
      out_tag_r    <= res_tag;
      out_occ_r    <= res_occupancy;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_status    = out_status_r;
  assign out_priority  = out_prio_r;
  assign out_tag       = out_tag_r;
  assign out_occupancy = out_occ_r;

  assign out_is_full  = out_valid && (out_status == STAT_FULL);
  assign out_is_empty = out_valid && (out_status == STAT_EMPTY);

  `SPQ_ASSERT_NEXT(a_one_in_flight, in_valid && in_ready, !in_ready, "request accepted while busy")
  `SPQ_ASSERT_NEXT(a_res_held, res_valid && !res_ready, res_valid, "pending result was lost")
  `SPQ_ASSERT_IMPL(a_occ_bound, out_valid, out_occupancy <= CNT_W'(DEPTH), "occupancy over depth")
  `SPQ_ASSERT_IMPL(a_full_occ, out_is_full, out_occupancy == CNT_W'(DEPTH), "full with room left")
  `SPQ_ASSERT_IMPL(a_empty_occ, out_is_empty, out_occupancy == '0, "empty with entries held")

endmodule

/* sim/stable_priority_queue_tb.sv */
`timescale 1ns / 100ps

module stable_priority_queue_tb;
  import spq_pkg::*;

  localparam int DEPTH      = DEPTH_DEF;
  localparam int TAG_BITS   = TAG_BITS_DEF;
  localparam int CNT_W      = $clog2(DEPTH + 1);
  localparam int N_ROWS     = 12;
  localparam int RAND_ITEMS = 2000;
  localparam int TAIL_ITEMS = 150;
  localparam int HOLD_AT    = 600;
  localparam int LONG_HOLD  = 300;
  localparam int PAUSE_AT   = 1200;
  localparam int MAX_SHOWN  = 10;

  typedef struct packed {
    status_t             status;
    logic [PRIO_W-1:0]   prio;
    logic [TAG_BITS-1:0] tag;
    logic [CNT_W-1:0]    occ;
  } outcome_t;

  typedef struct packed {
    logic                func;
    logic [PRIO_W-1:0]   prio;
    logic [TAG_BITS-1:0] tag;
    logic [4:0]          reps;
    logic                typed;
    outcome_t            want;
  } stim_row_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid;
  logic                in_ready;
  logic                in_func;
  logic [PRIO_W-1:0]   in_priority_req;
  logic [TAG_BITS-1:0] in_tag;
  logic                out_valid;
  logic                out_ready;
  logic [1:0]          out_status;
  logic [PRIO_W-1:0]   out_priority;
  logic [TAG_BITS-1:0] out_tag;
  logic [CNT_W-1:0]    out_occupancy;

  logic [PRIO_W-1:0]   held_prio [DEPTH];
  logic [TAG_BITS-1:0] held_tag [DEPTH];
  int                  held_count;

  outcome_t            queue_outcomes [$];
  int                  mismatches = 0;
  int                  served_cnt = 0;
  bit                  quiet = 1'b0;
  bit                  tx_idle_on = 1'b1;

  // The rows that carry a typed result can be read straight off the queue contents.
  stim_row_t stim_rows [N_ROWS] = '{
    '{FUNC_DEQ, 4'd0,  16'h0000, 5'd1,  1'b1, '{STAT_EMPTY, 4'd0,  16'h0000, 5'd0}},
    '{FUNC_ENQ, 4'd15, 16'hFFFF, 5'd1,  1'b1, '{STAT_ENQ,   4'd0,  16'h0000, 5'd1}},
    '{FUNC_ENQ, 4'd0,  16'h0000, 5'd1,  1'b1, '{STAT_ENQ,   4'd0,  16'h0000, 5'd2}},
    '{FUNC_ENQ, 4'd15, 16'h1234, 5'd1,  1'b0, '{STAT_ENQ,   4'd0,  16'h0000, 5'd0}},
    '{FUNC_ENQ, 4'd7,  16'h5A50, 5'd13, 1'b0, '{STAT_ENQ,   4'd0,  16'h0000, 5'd0}},
    '{FUNC_ENQ, 4'd9,  16'hABCD, 5'd1,  1'b1, '{STAT_FULL,  4'd0,  16'h0000, 5'd16}},
    '{FUNC_DEQ, 4'd0,  16'h0000, 5'd1,  1'b1, '{STAT_DEQ,   4'd15, 16'hFFFF, 5'd15}},
    '{FUNC_DEQ, 4'd0,  16'h0000, 5'd1,  1'b0, '{STAT_ENQ,   4'd0,  16'h0000, 5'd0}},
    '{FUNC_DEQ, 4'd0,  16'h0000, 5'd1,  1'b0, '{STAT_ENQ,   4'd0,  16'h0000, 5'd0}},
    '{FUNC_ENQ, 4'd7,  16'h7777, 5'd1,  1'b0, '{STAT_ENQ,   4'd0,  16'h0000, 5'd0}},
    '{FUNC_ENQ, 4'd8,  16'h8888, 5'd1,  1'b0, '{STAT_ENQ,   4'd0,  16'h0000, 5'd0}},
    '{FUNC_DEQ, 4'd0,  16'h0000, 5'd1,  1'b0, '{STAT_ENQ,   4'd0,  16'h0000, 5'd0}}
  };

  stable_priority_queue u_top (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_func         (in_func),
    .in_priority_req (in_priority_req),
    .in_tag          (in_tag),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_status      (out_status),
    .out_priority    (out_priority),
    .out_tag         (out_tag),
    .out_occupancy   (out_occupancy)
  );

  always #2 clk = ~clk;

  initial begin
    #2_000_000;
    $display("Mismatches found");
    $finish;
  end

  // A new entry goes behind every held entry of greater or equal priority.
  task automatic apply_queue_op(input logic f, input logic [PRIO_W-1:0] p,
                                input logic [TAG_BITS-1:0] t, output outcome_t res);
    int pos;
    int i;
    res = '0;
    res.status = STAT_ENQ;
    if (f == FUNC_ENQ) begin
      if (held_count >= DEPTH) begin
        res.status = STAT_FULL;
      end else begin
        pos = 0;
        while (pos < held_count && p <= held_prio[pos]) pos++;
        for (i = held_count; i > pos; i--) begin
          held_prio[i] = held_prio[i-1];
          held_tag[i]  = held_tag[i-1];
        end
        held_prio[pos] = p;
        held_tag[pos]  = t;
        held_count++;
      end
    end else begin
      if (held_count == 0) begin
        res.status = STAT_EMPTY;
      end else begin
        res.status = STAT_DEQ;
        res.prio   = held_prio[0];
        res.tag    = held_tag[0];
        for (i = 1; i < held_count; i++) begin
          held_prio[i-1] = held_prio[i];
          held_tag[i-1]  = held_tag[i];
        end
        held_count--;
      end
    end
    res.occ = held_count[CNT_W-1:0];
  endtask

  task automatic offer(input logic f, input logic [PRIO_W-1:0] p,
                       input logic [TAG_BITS-1:0] t, input logic typed, input outcome_t want);
    outcome_t got;
    in_valid        <= 1'b1;
    in_func         <= f;
    in_priority_req <= p;
    in_tag          <= t;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    apply_queue_op(f, p, t, got);
    queue_outcomes.push_back(typed ? want : got);
  endtask

  task automatic idle_burst();
    if (tx_idle_on && !quiet && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
  endtask

  initial begin
    int r;
    int k;
    int n;
    int enq_pct;
    bit narrow;
    logic f;
    logic [PRIO_W-1:0] p;
    in_valid        <= 1'b0;
    in_func         <= FUNC_ENQ;
    in_priority_req <= '0;
    in_tag          <= '0;
    held_count = 0;
    enq_pct = 50;
    narrow = 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    for (r = 0; r < N_ROWS; r++) begin
      for (k = 0; k < stim_rows[r].reps; k++) begin
        idle_burst();
        offer(stim_rows[r].func, stim_rows[r].prio, stim_rows[r].tag + TAG_BITS'(k),
              stim_rows[r].typed, stim_rows[r].want);
      end
    end

    // Phases swing the enqueue share so that the store runs both full and empty.
    for (n = 0; n < RAND_ITEMS; n++) begin
      if (n % 50 == 0) begin
        case ($urandom_range(0, 3))
          0: enq_pct = 25;
          1: enq_pct = 50;
          2: enq_pct = 75;
          default: enq_pct = 95;
        endcase
        narrow = ($urandom_range(0, 1) != 0);
        tx_idle_on = $urandom_range(0, 2) != 0;
      end
      quiet = (n >= RAND_ITEMS - TAIL_ITEMS);
      if (n == PAUSE_AT) begin
        in_valid <= 1'b0;
        do @(posedge clk); while (queue_outcomes.size() != 0);
      end else begin
        idle_burst();
      end
      f = ($urandom_range(1, 100) <= enq_pct) ? FUNC_ENQ : FUNC_DEQ;
      p = narrow ? PRIO_W'($urandom_range(6, 8)) : PRIO_W'($urandom_range(0, 15));
      offer(f, p, TAG_BITS'($urandom), 1'b0, '0);
    end

    in_valid <= 1'b0;
    do @(posedge clk); while (queue_outcomes.size() != 0);
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // The long hold keeps a result from leaving, so the queue stops taking requests.
  initial begin
    int cyc;
    int n;
    bit rx_stall_on;
    bit held_long;
    out_ready <= 1'b0;
    cyc = 0;
    rx_stall_on = 1'b0;
    held_long = 1'b0;
    while (!rst_n) @(posedge clk);
    forever begin
      if (cyc % 100 == 0) rx_stall_on = $urandom_range(0, 2) != 0;
      if (!held_long && !quiet && served_cnt >= HOLD_AT) begin
        held_long = 1'b1;
        out_ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        cyc += LONG_HOLD;
      end else if (rx_stall_on && !quiet && $urandom_range(0, 5) == 0) begin
        out_ready <= 1'b0;
        n = $urandom_range(1, 5);
        repeat (n) @(posedge clk);
        cyc += n;
      end else begin
        out_ready <= 1'b1;
        @(posedge clk);
        cyc++;
      end
    end
  end

  always @(posedge clk) begin
    outcome_t want;
    if (rst_n && out_valid && out_ready) begin
      served_cnt++;
      if (queue_outcomes.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_SHOWN)
          $display("unrequested result: status %0d prio %0d tag %h occupancy %0d",
                   out_status, out_priority, out_tag, out_occupancy);
      end else begin
        want = queue_outcomes.pop_front();
        if (out_status !== want.status || out_priority !== want.prio ||
            out_tag !== want.tag || out_occupancy !== want.occ) begin
          mismatches++;
          if (mismatches <= MAX_SHOWN)
            $display("result %0d: want status %0d prio %0d tag %h occ %0d, got %0d %0d %h %0d",
                     served_cnt, want.status, want.prio, want.tag, want.occ,
                     out_status, out_priority, out_tag, out_occupancy);
        end
      end
    end
  end

endmodule
